[rtl/bbc_pkg.sv]
// Shared types and constants of the buffer cache tag table.
// Depends on nothing; used by bbc_ctrl, bbc_datapath and the top level.
`default_nettype none

package bbc_pkg;

   localparam int NUM_BUFFERS = 32;
   localparam int SLOT_W      = $clog2(NUM_BUFFERS);
   localparam int DEV_W       = 8;
   localparam int BLK_W       = 32;
   localparam int REFS_W      = 8;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 16;

   localparam logic [REFS_W-1:0] REFS_MAX = '1;

   typedef enum logic [1:0] {
      OP_GET     = 2'd0,
      OP_RELEASE = 2'd1,
      OP_PIN     = 2'd2,
      OP_UNPIN   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOBUF   = 2'd1,
      ST_NOTHELD = 2'd2
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch the request beat
      logic lookup;    // register tag match / free slot search
      logic commit;    // update table, load response register
   } cmd_type;

endpackage

`default_nettype wire

[rtl/bbc_ctrl.sv]
// Sequencer of the buffer cache tag table: request/response handshake.
// Depends on bbc_pkg.
`default_nettype none

module bbc_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   output bbc_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_LOOKUP = 3'b010,
      S_COMMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      commit;
   logic      capture;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = (state_ff == S_COMMIT) && out_free;
   assign req_tready = (state_ff == S_IDLE) || commit;
   assign capture    = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   assign cmd.capture = capture;
   assign cmd.lookup  = (state_ff == S_LOOKUP);
   assign cmd.commit  = commit;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (capture) state_in = S_LOOKUP;
         end
         S_LOOKUP: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (commit) state_in = capture ? S_LOOKUP : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (commit)          rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[rtl/bbc_datapath.sv]
// Datapath of the buffer cache tag table: slot table, tag compare,
// free slot search, count update and response register. Depends on bbc_pkg.
`default_nettype none

module bbc_datapath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire bbc_pkg::cmd_type                   cmd,
   input  wire logic [bbc_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic      [bbc_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int N = bbc_pkg::NUM_BUFFERS;
   localparam int SW = bbc_pkg::SLOT_W;

   // slot table
   logic [bbc_pkg::DEV_W-1:0]  dev_ff  [N];
   logic [bbc_pkg::BLK_W-1:0]  blk_ff  [N];
   logic [bbc_pkg::REFS_W-1:0] refs_ff [N];
   logic [N-1:0]               busy_ff;
   logic [N-1:0]               loaded_ff;

   // request register
   bbc_pkg::op_type            op_ff;
   logic [bbc_pkg::DEV_W-1:0]  rdev_ff;
   logic [bbc_pkg::BLK_W-1:0]  rblk_ff;
   logic [SW-1:0]              rslot_ff;

   // lookup result register
   logic [SW-1:0] tgt_ff, tgt_in;
   logic          hit_ff, hit_in;
   logic          found_ff, found_in;

   // response register
   logic [SW-1:0]         out_slot_ff, out_slot_in;
   logic                  out_hit_ff, out_hit_in;
   logic                  out_rd_ff, out_rd_in;
   bbc_pkg::status_type   out_st_ff, out_st_in;

   logic [N-1:0]  match;
   logic [SW-1:0] match_idx, free_idx;
   logic          any_free;

   logic [bbc_pkg::REFS_W-1:0] cur_refs, new_refs;
   logic                       wr_refs, wr_claim, wr_free, wr_loaded;

   always_comb begin
      for (int i = 0; i < N; i++) begin
         match[i] = busy_ff[i] && (dev_ff[i] == rdev_ff) && (blk_ff[i] == rblk_ff);
      end
   end

   // lowest index wins
   always_comb begin
      match_idx = '0;
      free_idx  = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (match[i])    match_idx = SW'(i);
         if (!busy_ff[i]) free_idx  = SW'(i);
      end
      any_free = !(&busy_ff);
   end

   always_comb begin
      if (op_ff == bbc_pkg::OP_GET) begin
         hit_in   = |match;
         tgt_in   = (|match) ? match_idx : free_idx;
         found_in = (|match) || any_free;
      end else begin
         hit_in   = 1'b0;
         tgt_in   = rslot_ff;
         found_in = busy_ff[rslot_ff];
      end
   end

   // commit: table update and response
   assign cur_refs = refs_ff[tgt_ff];

   always_comb begin
      new_refs    = cur_refs;
      wr_refs     = 1'b0;
      wr_claim    = 1'b0;
      wr_free     = 1'b0;
      wr_loaded   = 1'b0;
      out_slot_in = tgt_ff;
      out_hit_in  = 1'b0;
      out_rd_in   = 1'b0;
      out_st_in   = bbc_pkg::ST_OK;
      unique case (op_ff)
         bbc_pkg::OP_GET: begin
            if (hit_ff) begin
               out_hit_in = 1'b1;
               out_rd_in  = !loaded_ff[tgt_ff];
               wr_loaded  = 1'b1;
               wr_refs    = 1'b1;
               if (cur_refs != bbc_pkg::REFS_MAX) new_refs = cur_refs + 1'b1;
            end else if (found_ff) begin
               out_rd_in = 1'b1;
               wr_claim  = 1'b1;
               wr_refs   = 1'b1;
               new_refs  = bbc_pkg::REFS_W'(1);
            end else begin
               out_slot_in = '0;
               out_st_in   = bbc_pkg::ST_NOBUF;
            end
         end
         bbc_pkg::OP_PIN: begin
            if (!found_ff) begin
               out_st_in = bbc_pkg::ST_NOTHELD;
            end else begin
               wr_refs = 1'b1;
               if (cur_refs != bbc_pkg::REFS_MAX) new_refs = cur_refs + 1'b1;
            end
         end
         bbc_pkg::OP_RELEASE, bbc_pkg::OP_UNPIN: begin
            if (!found_ff || cur_refs == '0) begin
               out_st_in = bbc_pkg::ST_NOTHELD;
            end else begin
               wr_refs  = 1'b1;
               new_refs = cur_refs - 1'b1;
               wr_free  = (op_ff == bbc_pkg::OP_RELEASE) &&
                          (cur_refs == bbc_pkg::REFS_W'(1));
            end
         end
         default: begin
            out_st_in = bbc_pkg::ST_NOTHELD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= bbc_pkg::op_type'(req_tdata[1:0]);
         rdev_ff  <= req_tdata[9:2];
         rblk_ff  <= req_tdata[41:10];
         rslot_ff <= req_tdata[46:42];
      end
      if (cmd.lookup) begin
         tgt_ff   <= tgt_in;
         hit_ff   <= hit_in;
         found_ff <= found_in;
      end
      if (cmd.commit) begin
         out_slot_ff <= out_slot_in;
         out_hit_ff  <= out_hit_in;
         out_rd_ff   <= out_rd_in;
         out_st_ff   <= out_st_in;
      end
      if (cmd.commit && wr_claim) begin
         dev_ff[tgt_ff] <= rdev_ff;
         blk_ff[tgt_ff] <= rblk_ff;
      end
   end

   // control state of the table
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= '0;
         loaded_ff <= '0;
         for (int i = 0; i < N; i++) refs_ff[i] <= '0;
      end else if (cmd.commit) begin
         if (wr_refs)             refs_ff[tgt_ff]   <= new_refs;
         if (wr_claim)            busy_ff[tgt_ff]   <= 1'b1;
         if (wr_free)             busy_ff[tgt_ff]   <= 1'b0;
         if (wr_claim || wr_loaded) loaded_ff[tgt_ff] <= 1'b1;
      end
   end

   assign rsp_tdata = {7'd0, out_st_ff, out_rd_ff, out_hit_ff, out_slot_ff};

endmodule

`default_nettype wire

[rtl/block_buffer_cache_table_core.sv]
// Top level of the buffer cache tag table.
// Depends on bbc_pkg, bbc_ctrl and bbc_datapath.
`default_nettype none

// Usage
//  - req_* stream: one beat per request (get, release, pin, unpin).
//    A beat is taken when req_tvalid and req_tready are both high.
//  - rsp_* stream: exactly one beat per request, in request order.
//  - A request passes the request, lookup result and response registers
//    on its way to rsp_*. Its lookup step runs the tag compare across all
//    32 slots and the lowest-free-slot search into a register; its commit
//    step reads the count of the chosen slot, updates the table and loads
//    the response register. The next beat is taken in the commit cycle.
//  - Get: hit raises the count (saturates at 255); miss claims the lowest
//    free slot with count 1; a full table gives status no-buffer.
//  - Release/pin/unpin of a free slot, or release/unpin at count zero,
//    give status not-held and leave the table alone.
//  - Reset (synchronous, active high) frees all slots, clears counts and
//    loaded marks and drops rsp_tvalid. Tags stay as they are; they are
//    compared only on busy slots.
//  - Receiver stall: a response waits in the output register; the block
//    finishes the following lookup and then holds until the response
//    register frees, with req_tready low.
module block_buffer_cache_table_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] op, [9:2] device_id, [41:10] block_number, [46:42] slot_index,
   // [47] zero
   input  wire logic [47:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [4:0] result_slot, [5] hit, [6] needs_read, [8:7] status, [15:9] zero
   output logic [15:0]      rsp_tdata
);

   bbc_pkg::cmd_type cmd;

   bbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   bbc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire
